// File: rtl/core/timer_and_interrupt_controller_top_defines.svh
// Assertion macros shared by the timer and interrupt controller.
`ifndef TIMER_AND_INTERRUPT_CONTROLLER_TOP_DEFINES_SVH
`define TIMER_AND_INTERRUPT_CONTROLLER_TOP_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define TIC_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tic: invariant violated");

// A condition that follows from another in the same cycle.
`define TIC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tic: implication violated");

// A condition that follows from another in the next cycle.
`define TIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tic: next-cycle implication violated");

`endif

// File: rtl/core/tic_pkg.sv
package tic_pkg;

    localparam int OpW        = 2;
    localparam int ClocksW    = 8;
    localparam int PcW        = 16;
    localparam int ReqW       = 3;
    localparam int ByteW      = 8;
    localparam int TimCdW     = 11;
    localparam int TimerCtlW  = 3;
    localparam int CfgIdxW    = 2;
    localparam int CfgDataW   = 8;
    localparam int TimerEnBit = 2;
    localparam int TimerSrc   = 2;

    localparam logic [ByteW-1:0]  DivReload  = 8'd255;
    localparam logic [ByteW-1:0]  ByteMax    = 8'hFF;
    localparam logic [ByteW-1:0]  VecBase    = 8'h40;
    localparam logic [TimCdW-1:0] TimCdReset = 11'd1024;

    typedef enum logic [OpW-1:0] {
        OpAdvance     = 2'd0,
        OpRaise       = 2'd1,
        OpSetMaster   = 2'd2,
        OpClearMaster = 2'd3
    } t_op;

    typedef enum logic [CfgIdxW-1:0] {
        CfgTimerControl = 2'd0,
        CfgTimerModulo  = 2'd1,
        CfgIeMask       = 2'd2
    } t_cfg_idx;

    function automatic logic [TimCdW-1:0] period_of(input logic [1:0] sel);
        logic [TimCdW-1:0] p;
        case (sel)
            2'd0:    p = 11'd1024;
            2'd1:    p = 11'd16;
            2'd2:    p = 11'd64;
            default: p = 11'd256;
        endcase
        return p;
    endfunction

endpackage

// File: rtl/core/tic_in_if.sv
interface tic_in_if import tic_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OpW-1:0]       operation;
    logic [ClocksW-1:0]   clocks;
    logic [PcW-1:0]       pc;
    logic [ReqW-1:0]      request_bit;

    modport source (output valid, operation, clocks, pc, request_bit, input ready);
    modport sink   (input valid, operation, clocks, pc, request_bit, output ready);
endinterface

// File: rtl/core/tic_out_if.sv
interface tic_out_if import tic_pkg::*; #(parameter int NUM_SOURCES = 5) ();
    logic                   valid;
    logic                   ready;
    logic                   serviced;
    logic [ByteW-1:0]       vector;
    logic [PcW-1:0]         return_pc;
    logic [NUM_SOURCES-1:0] pending;
    logic [ByteW-1:0]       divider;
    logic [ByteW-1:0]       timer_value;
    logic                   master_on;

    modport source (output valid, serviced, vector, return_pc, pending, divider,
                    timer_value, master_on, input ready);
    modport sink   (input valid, serviced, vector, return_pc, pending, divider,
                    timer_value, master_on, output ready);
endinterface

// File: rtl/core/tic_core.sv
`include "timer_and_interrupt_controller_top_defines.svh"

module tic_core import tic_pkg::*; #(
    parameter int NUM_SOURCES = 5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic [OpW-1:0]         i_operation,
    input  logic [ClocksW-1:0]     i_clocks,
    input  logic [PcW-1:0]         i_pc,
    input  logic [ReqW-1:0]        i_request_bit,
    input  logic [TimerCtlW-1:0]   i_timer_control,
    input  logic [ByteW-1:0]       i_timer_modulo,
    input  logic [NUM_SOURCES-1:0] i_ie_mask,
    output logic                   o_serviced,
    output logic [ByteW-1:0]       o_vector,
    output logic [PcW-1:0]         o_return_pc,
    output logic [NUM_SOURCES-1:0] o_pending,
    output logic [ByteW-1:0]       o_divider,
    output logic [ByteW-1:0]       o_timer_value,
    output logic                   o_master_on
);

    localparam int IdxW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

    logic [ByteW-1:0]       r_div_cd, n_div_cd;
    logic [TimCdW-1:0]      r_tim_cd, n_tim_cd;
    logic [ByteW-1:0]       r_div, n_div;
    logic [ByteW-1:0]       r_timer, n_timer;
    logic [NUM_SOURCES-1:0] r_pend, n_pend;
    logic                   r_master, n_master;

    t_op                    op;
    logic [TimCdW-1:0]      clocks_w;
    logic                   tim_ovf;
    logic                   raise_req;
    logic [NUM_SOURCES-1:0] pend_mid;
    logic [NUM_SOURCES-1:0] act;
    logic [IdxW-1:0]        idx;
    logic                   serviced;

    assign op       = t_op'(i_operation);
    assign clocks_w = TimCdW'(i_clocks);

    always_comb begin
        n_div_cd  = r_div_cd;
        n_div     = r_div;
        n_tim_cd  = r_tim_cd;
        n_timer   = r_timer;
        n_master  = r_master;
        tim_ovf   = 1'b0;
        raise_req = 1'b0;
        case (op)
            OpAdvance: begin
                if (i_clocks >= r_div_cd) begin
                    n_div_cd = DivReload;
                    n_div    = r_div + 8'd1;
                end else begin
                    n_div_cd = r_div_cd - i_clocks;
                end
                if (i_timer_control[TimerEnBit]) begin
                    if (clocks_w >= r_tim_cd) begin
                        n_tim_cd = period_of(i_timer_control[1:0]);
                        if (r_timer == ByteMax) begin
                            n_timer = i_timer_modulo;
                            tim_ovf = 1'b1;
                        end else begin
                            n_timer = r_timer + 8'd1;
                        end
                    end else begin
                        n_tim_cd = r_tim_cd - clocks_w;
                    end
                end
            end
            OpRaise:     raise_req = 1'b1;
            OpSetMaster: n_master  = 1'b1;
            default:     n_master  = 1'b0;
        endcase

        for (int i = 0; i < NUM_SOURCES; i++) begin
            pend_mid[i] = r_pend[i] | (tim_ovf && (i == TimerSrc))
                        | (raise_req && (ReqW'(i) == i_request_bit));
        end

        act = (op == OpAdvance && r_master) ? (pend_mid & i_ie_mask) : '0;

        // Scan downward so the lowest active source wins.
        idx = '0;
        for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
            if (act[i]) begin
                idx = IdxW'(i);
            end
        end
        serviced = |act;

        n_pend = pend_mid;
        if (serviced) begin
            n_pend[idx] = 1'b0;
            n_master    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cd <= DivReload;
            r_tim_cd <= TimCdReset;
            r_div    <= '0;
            r_timer  <= '0;
            r_pend   <= '0;
            r_master <= 1'b0;
        end else if (i_en) begin
            r_div_cd <= n_div_cd;
            r_tim_cd <= n_tim_cd;
            r_div    <= n_div;
            r_timer  <= n_timer;
            r_pend   <= n_pend;
            r_master <= n_master;
        end
    end

    assign o_serviced    = serviced;
    assign o_vector      = serviced ? (VecBase + (ByteW'(idx) << 3)) : '0;
    assign o_return_pc   = serviced ? i_pc : '0;
    assign o_pending     = n_pend;
    assign o_divider     = n_div;
    assign o_timer_value = n_timer;
    assign o_master_on   = n_master;

    `TIC_ASSERT_ALWAYS(a_div_cd_nonzero, i_clk, i_rst_n, r_div_cd != '0)
    `TIC_ASSERT_ALWAYS(a_tim_cd_range, i_clk, i_rst_n, (r_tim_cd != '0) && (r_tim_cd <= TimCdReset))
    `TIC_ASSERT_NEXT(a_service_drops_master, i_clk, i_rst_n, i_en && serviced, !r_master)
    `TIC_ASSERT_NEXT(a_hold_when_idle, i_clk, i_rst_n, !i_en, $stable(r_div_cd) && $stable(r_pend))

endmodule

// File: rtl/core/timer_and_interrupt_controller_top.sv
// Timer and interrupt controller.
// Items arrive on i_in (valid/ready) and carry an operation: advance by a
// clock count and check for an interrupt, raise a request bit, set the
// master enable or clear it. Each item yields exactly one result on o_out
// with the dispatch decision, the pending flags, the divider byte, the timer
// byte and the master enable as they stand after that item.
// Configuration (timer control, timer modulo, interrupt enable mask) is
// written through i_cfg_we/i_cfg_idx/i_cfg_data; the user must do so only
// while no item is in flight, since the block itself does not enforce this.
// An accepted item waits in the input register until the result register
// is free or taken; then the counter and priority logic updates the state
// and fills the result register. One item per cycle is sustained while
// results are taken; the next item sees the state update of the last.
// If the receiver stalls, the result register holds and the input register
// still takes one more item; ready drops only when both are full.
// Synchronous reset empties both registers, clears the configuration,
// loads the countdowns with 255 and 1024 and clears bytes, flags and master.
module timer_and_interrupt_controller_top import tic_pkg::*; #(
    parameter int NUM_SOURCES = 5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    tic_in_if.sink                 i_in,
    tic_out_if.source              o_out,
    input  logic                   i_cfg_we,
    input  logic [CfgIdxW-1:0]     i_cfg_idx,
    input  logic [CfgDataW-1:0]    i_cfg_data
);

    logic [TimerCtlW-1:0]   r_timer_control;
    logic [ByteW-1:0]       r_timer_modulo;
    logic [NUM_SOURCES-1:0] r_ie_mask;

    logic                   r_in_vld;
    logic [OpW-1:0]         r_in_op;
    logic [ClocksW-1:0]     r_in_clocks;
    logic [PcW-1:0]         r_in_pc;
    logic [ReqW-1:0]        r_in_req;

    logic                   r_out_vld;
    logic                   r_out_serviced;
    logic [ByteW-1:0]       r_out_vector;
    logic [PcW-1:0]         r_out_return_pc;
    logic [NUM_SOURCES-1:0] r_out_pending;
    logic [ByteW-1:0]       r_out_divider;
    logic [ByteW-1:0]       r_out_timer_value;
    logic                   r_out_master_on;

    logic                   step;
    logic                   in_take;
    logic                   c_serviced;
    logic [ByteW-1:0]       c_vector;
    logic [PcW-1:0]         c_return_pc;
    logic [NUM_SOURCES-1:0] c_pending;
    logic [ByteW-1:0]       c_divider;
    logic [ByteW-1:0]       c_timer_value;
    logic                   c_master_on;

    assign step       = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || step;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_control <= '0;
            r_timer_modulo  <= '0;
            r_ie_mask       <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CfgTimerControl: r_timer_control <= i_cfg_data[TimerCtlW-1:0];
                CfgTimerModulo:  r_timer_modulo  <= i_cfg_data[ByteW-1:0];
                CfgIeMask:       r_ie_mask       <= i_cfg_data[NUM_SOURCES-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (step) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op     <= i_in.operation;
            r_in_clocks <= i_in.clocks;
            r_in_pc     <= i_in.pc;
            r_in_req    <= i_in.request_bit;
        end
    end

    tic_core #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (step),
        .i_operation     (r_in_op),
        .i_clocks        (r_in_clocks),
        .i_pc            (r_in_pc),
        .i_request_bit   (r_in_req),
        .i_timer_control (r_timer_control),
        .i_timer_modulo  (r_timer_modulo),
        .i_ie_mask       (r_ie_mask),
        .o_serviced      (c_serviced),
        .o_vector        (c_vector),
        .o_return_pc     (c_return_pc),
        .o_pending       (c_pending),
        .o_divider       (c_divider),
        .o_timer_value   (c_timer_value),
        .o_master_on     (c_master_on)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_serviced    <= c_serviced;
            r_out_vector      <= c_vector;
            r_out_return_pc   <= c_return_pc;
            r_out_pending     <= c_pending;
            r_out_divider     <= c_divider;
            r_out_timer_value <= c_timer_value;
            r_out_master_on   <= c_master_on;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.serviced    = r_out_serviced;
    assign o_out.vector      = r_out_vector;
    assign o_out.return_pc   = r_out_return_pc;
    assign o_out.pending     = r_out_pending;
    assign o_out.divider     = r_out_divider;
    assign o_out.timer_value = r_out_timer_value;
    assign o_out.master_on   = r_out_master_on;

endmodule
